// File: hdl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types, constants and the dither ranking for the dual stepper
// step generator.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int SPEED_W    = 16;
    localparam int MAXS_W     = 15;
    localparam int ACC_W      = 8;
    localparam int RATE_W     = 16;
    localparam int CNT_W      = 16;
    localparam int SUB_PERIODS = 8;
    localparam int IDX_W      = 3;
    localparam int EXTRA_W    = 3;
    localparam int DIV_W      = RATE_W + EXTRA_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] IDLE_PERIOD = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SPEED_CAP  = 2'd0,
        REG_ACCEL_STEP = 2'd1,
        REG_RATE_NUM   = 2'd2,
        REG_REVERSE    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        FUNC_SET_SPEED = 1'b0,
        FUNC_TICK      = 1'b1
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } back_state_t;

    typedef struct packed {
        logic                      is_tick;
        logic                      motor;
        logic signed [SPEED_W-1:0] target;
    } dss_cmd_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [SPEED_W-1:0] divisor;
    } dss_div_req_t;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quotient;
    } dss_div_status_t;

    // position of a sub-period in the lengthening order 1,5,3,7,0,4,2
    function automatic logic [IDX_W-1:0] dither_rank(input logic [IDX_W-1:0] k);
        logic [IDX_W-1:0] r;
        unique case (k)
            3'd0: r = 3'd4;
            3'd1: r = 3'd0;
            3'd2: r = 3'd6;
            3'd3: r = 3'd2;
            3'd4: r = 3'd5;
            3'd5: r = 3'd1;
            3'd6: r = 3'd7;
            3'd7: r = 3'd3;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/dss_front.sv
// ----------------------------------------------------------------------------
// dss_front
// Accepts input transactions, clamps set-speed targets and queues the
// decoded commands for the back end.
// ----------------------------------------------------------------------------
module dss_front import dss_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_func,
    input  logic                      s_motor,
    input  logic signed [SPEED_W-1:0] s_speed,
    input  logic [MAXS_W-1:0]         speed_cap,
    output logic                      cmd_valid,
    input  logic                      cmd_pop,
    output dss_cmd_t                  cmd
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    dss_cmd_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic                  push, pop;
    logic signed [SPEED_W-1:0] lim, lim_neg;
    dss_cmd_t              dec;

    // clamp target to the configured limit
    always_comb begin
        lim          = signed'({1'b0, speed_cap});
        lim_neg      = -lim;
        dec.is_tick  = (func_t'(s_func) == FUNC_TICK);
        dec.motor    = s_motor;
        if (s_speed > lim) begin
            dec.target = lim;
        end else if (s_speed < lim_neg) begin
            dec.target = lim_neg;
        end else begin
            dec.target = s_speed;
        end
    end

    assign s_ready   = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// File: hdl/dss_divider.sv
// ----------------------------------------------------------------------------
// dss_divider
// Restoring radix-2 divider, one quotient bit per cycle. The dividend is the
// rate numerator shifted by three, so the low quotient bits are the eighths.
// ----------------------------------------------------------------------------
module dss_divider import dss_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  dss_div_req_t    req,
    output dss_div_status_t status
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic                busy_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SPEED_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [SPEED_W-1:0]  dvs_reg;
    logic [SPEED_W:0]    rem_shift, rem_sub;
    logic                ge;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        ge        = (rem_shift >= {1'b0, dvs_reg});
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        rem_next  = ge ? rem_sub[SPEED_W-1:0] : rem_shift[SPEED_W-1:0];
        quo_next  = {quo_reg[DIV_W-2:0], ge};
    end

    assign status.busy     = busy_reg;
    assign status.quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(DIV_W);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

// File: hdl/dss_back.sv
// ----------------------------------------------------------------------------
// dss_back
// Executes queued commands: per-motor tick lanes, speed ramping and period
// fill through the divider, and the result output register.
// ----------------------------------------------------------------------------
module dss_back import dss_pkg::*; #(
    parameter int MOTOR_COUNT = 2
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cmd_valid,
    output logic                      cmd_pop,
    input  dss_cmd_t                  cmd,
    input  logic [ACC_W-1:0]          accel_step,
    input  logic [RATE_W-1:0]         rate_numerator,
    input  logic                      reverse_direction,
    output dss_div_req_t              div_req,
    input  dss_div_status_t           div_status,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_step_first,
    output logic                      m_step_second,
    output logic                      m_dir_first,
    output logic                      m_dir_second,
    output logic                      m_drivers_disabled,
    output logic signed [SPEED_W-1:0] m_speed_first,
    output logic signed [SPEED_W-1:0] m_speed_second
);

    back_state_t state_reg, state_next;

    logic signed [SPEED_W-1:0] speed_reg  [MOTOR_COUNT];
    logic signed [SPEED_W-1:0] speed_next [MOTOR_COUNT];
    logic                      dirm_reg   [MOTOR_COUNT];
    logic                      dirm_next  [MOTOR_COUNT];
    logic                      stop_reg   [MOTOR_COUNT];
    logic                      stop_next  [MOTOR_COUNT];
    logic [CNT_W-1:0]          base_reg   [MOTOR_COUNT];
    logic [CNT_W-1:0]          base_next  [MOTOR_COUNT];
    logic [EXTRA_W-1:0]        extra_reg  [MOTOR_COUNT];
    logic [EXTRA_W-1:0]        extra_next [MOTOR_COUNT];
    logic [CNT_W-1:0]          cnt_reg    [MOTOR_COUNT];
    logic [CNT_W-1:0]          cnt_next   [MOTOR_COUNT];
    logic [IDX_W-1:0]          idx_reg    [MOTOR_COUNT];
    logic [IDX_W-1:0]          idx_next   [MOTOR_COUNT];
    logic                      pin_reg    [MOTOR_COUNT];
    logic                      pin_next   [MOTOR_COUNT];
    logic                      step_vec   [MOTOR_COUNT];
    logic                      dis_reg, dis_next;
    logic                      cur_motor_reg;

    logic                      m_valid_reg;
    logic                      step0_reg, step1_reg, dir0_reg, dir1_reg, dis_out_reg;
    logic signed [SPEED_W-1:0] spd0_reg, spd1_reg;

    logic                      sec_step, sec_pin;
    logic signed [SPEED_W-1:0] sec_speed;

    logic                      out_free, motor_ok;
    logic                      do_tick, do_set, do_fill, load_out;
    logic signed [SPEED_W:0]   tg, sp, acc, diff, nv;
    logic [SPEED_W-1:0]        mag, mag_sel;
    logic [CNT_W-1:0]          period, cnt_inc;
    logic                      longer, all_zero;

    assign out_free = !m_valid_reg || m_ready;
    assign motor_ok = (int'(cmd.motor) < MOTOR_COUNT);

    // sequencer
    always_comb begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        do_tick    = 1'b0;
        do_set     = 1'b0;
        do_fill    = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.is_tick) begin
                        if (out_free) begin
                            cmd_pop  = 1'b1;
                            do_tick  = 1'b1;
                            load_out = 1'b1;
                        end
                    end else if (motor_ok) begin
                        cmd_pop    = 1'b1;
                        do_set     = 1'b1;
                        state_next = ST_DIV;
                    end else if (out_free) begin
                        cmd_pop  = 1'b1;
                        load_out = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (!div_status.busy && out_free) begin
                    do_fill    = 1'b1;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // motor lanes
    always_comb begin
        mag_sel  = '0;
        all_zero = 1'b1;
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            speed_next[m] = speed_reg[m];
            dirm_next[m]  = dirm_reg[m];
            stop_next[m]  = stop_reg[m];
            base_next[m]  = base_reg[m];
            extra_next[m] = extra_reg[m];
            cnt_next[m]   = cnt_reg[m];
            idx_next[m]   = idx_reg[m];
            pin_next[m]   = pin_reg[m];
            step_vec[m]   = 1'b0;

            // ramp toward the clamped target
            tg   = (SPEED_W+1)'(cmd.target);
            sp   = (SPEED_W+1)'(speed_reg[m]);
            acc  = signed'({{(SPEED_W+1-ACC_W){1'b0}}, accel_step});
            diff = tg - sp;
            if (diff > acc) begin
                nv = sp + acc;
            end else if (diff < -acc) begin
                nv = sp - acc;
            end else begin
                nv = tg;
            end
            mag = nv[SPEED_W-1] ? SPEED_W'(-nv) : nv[SPEED_W-1:0];
            if (do_set && (int'(cmd.motor) == m)) begin
                speed_next[m] = nv[SPEED_W-1:0];
                mag_sel       = mag;
            end

            if (do_fill && (int'(cur_motor_reg) == m)) begin
                if (speed_reg[m] == '0) begin
                    stop_next[m] = 1'b1;
                end else begin
                    stop_next[m]  = 1'b0;
                    dirm_next[m]  = speed_reg[m][SPEED_W-1] ^ reverse_direction;
                    base_next[m]  = div_status.quotient[DIV_W-1:EXTRA_W];
                    extra_next[m] = div_status.quotient[EXTRA_W-1:0];
                end
            end

            // tick counter against the current sub-period
            longer  = (dither_rank(idx_reg[m]) < extra_reg[m]);
            period  = stop_reg[m] ? IDLE_PERIOD
                                  : base_reg[m] + {{(CNT_W-1){1'b0}}, longer};
            cnt_inc = cnt_reg[m] + 1'b1;
            if (do_tick) begin
                if (cnt_inc >= period) begin
                    cnt_next[m] = '0;
                    if (!stop_reg[m]) begin
                        pin_next[m] = dirm_reg[m];
                        idx_next[m] = idx_reg[m] + 1'b1;
                        step_vec[m] = 1'b1;
                    end
                end else begin
                    cnt_next[m] = cnt_inc;
                end
            end

            if (speed_next[m] != '0) begin
                all_zero = 1'b0;
            end
        end
        dis_next = do_set ? all_zero : dis_reg;
    end

    assign div_req.start    = do_set;
    assign div_req.dividend = {rate_numerator, {EXTRA_W{1'b0}}};
    assign div_req.divisor  = mag_sel;

    if (MOTOR_COUNT > 1) begin : g_second
        assign sec_step  = step_vec[1];
        assign sec_pin   = pin_next[1];
        assign sec_speed = speed_next[1];
    end else begin : g_no_second
        assign sec_step  = 1'b0;
        assign sec_pin   = 1'b0;
        assign sec_speed = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            dis_reg     <= 1'b0;
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                speed_reg[m] <= '0;
                dirm_reg[m]  <= 1'b0;
                stop_reg[m]  <= 1'b1;
                cnt_reg[m]   <= '0;
                idx_reg[m]   <= '0;
                pin_reg[m]   <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            dis_reg   <= dis_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                speed_reg[m] <= speed_next[m];
                dirm_reg[m]  <= dirm_next[m];
                stop_reg[m]  <= stop_next[m];
                cnt_reg[m]   <= cnt_next[m];
                idx_reg[m]   <= idx_next[m];
                pin_reg[m]   <= pin_next[m];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            base_reg[m]  <= base_next[m];
            extra_reg[m] <= extra_next[m];
        end
        if (do_set) begin
            cur_motor_reg <= cmd.motor;
        end
        if (load_out) begin
            step0_reg   <= step_vec[0];
            step1_reg   <= sec_step;
            dir0_reg    <= pin_next[0];
            dir1_reg    <= sec_pin;
            dis_out_reg <= dis_next;
            spd0_reg    <= speed_next[0];
            spd1_reg    <= sec_speed;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_step_first       = step0_reg;
    assign m_step_second      = step1_reg;
    assign m_dir_first        = dir0_reg;
    assign m_dir_second       = dir1_reg;
    assign m_drivers_disabled = dis_out_reg;
    assign m_speed_first      = spd0_reg;
    assign m_speed_second     = spd1_reg;

endmodule

// File: hdl/dual_stepper_step_generator_unit.sv
// a tick transaction reaches the result through the command queue and the
// result register; a set-speed passes ramp, 19-step divider and fill
// throughput: one tick per cycle unless the result side stalls; a set-speed
// holds the back end in ST_DIV until the one-bit-per-cycle divider is done;
// a 2-entry queue decouples the input. reset: aresetn is synchronous active
// low; control and config registers return to defaults with no clearing pass
// ----------------------------------------------------------------------------
// dual_stepper_step_generator_unit
// Two-motor stepper step-pulse generator with fractional period dither.
// ----------------------------------------------------------------------------
module dual_stepper_step_generator_unit import dss_pkg::*; #(
    parameter int MOTOR_COUNT = 2
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_func,
    input  logic                      s_motor,
    input  logic signed [SPEED_W-1:0] s_speed,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_step_first,
    output logic                      m_step_second,
    output logic                      m_dir_first,
    output logic                      m_dir_second,
    output logic                      m_drivers_disabled,
    output logic signed [SPEED_W-1:0] m_speed_first,
    output logic signed [SPEED_W-1:0] m_speed_second
);

    logic [MAXS_W-1:0] speed_cap_reg;
    logic [ACC_W-1:0]  accel_step_reg;
    logic [RATE_W-1:0] rate_num_reg;
    logic              reverse_reg;

    logic              cmd_valid, cmd_pop;
    dss_cmd_t          cmd;
    dss_div_req_t      div_req;
    dss_div_status_t   div_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_cap_reg  <= MAXS_W'(500);
            accel_step_reg <= ACC_W'(4);
            rate_num_reg   <= RATE_W'(1000);
            reverse_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SPEED_CAP:  speed_cap_reg  <= cfg_wdata[MAXS_W-1:0];
                REG_ACCEL_STEP: accel_step_reg <= cfg_wdata[ACC_W-1:0];
                REG_RATE_NUM:   rate_num_reg   <= cfg_wdata[RATE_W-1:0];
                REG_REVERSE:    reverse_reg    <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    dss_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_motor   (s_motor),
        .s_speed   (s_speed),
        .speed_cap (speed_cap_reg),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    dss_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .status  (div_status)
    );

    dss_back #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd_valid          (cmd_valid),
        .cmd_pop            (cmd_pop),
        .cmd                (cmd),
        .accel_step         (accel_step_reg),
        .rate_numerator     (rate_num_reg),
        .reverse_direction  (reverse_reg),
        .div_req            (div_req),
        .div_status         (div_status),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_step_first       (m_step_first),
        .m_step_second      (m_step_second),
        .m_dir_first        (m_dir_first),
        .m_dir_second       (m_dir_second),
        .m_drivers_disabled (m_drivers_disabled),
        .m_speed_first      (m_speed_first),
        .m_speed_second     (m_speed_second)
    );

endmodule

// File: hdl/dss_checker.sv
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dss_checker import dss_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_step_first,
    input logic                      m_step_second,
    input logic                      m_drivers_disabled,
    input logic signed [SPEED_W-1:0] m_speed_first,
    input logic signed [SPEED_W-1:0] m_speed_second
);

    // stalled result transaction stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // stalled result transaction keeps its speed and driver-disable fields
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_speed_first) && $stable(m_speed_second)
                                && $stable(m_drivers_disabled))
        else $error("result payload changed while stalled");

    // drivers are only disabled with both motors at rest
    a_disable_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drivers_disabled |-> m_speed_first == '0 && m_speed_second == '0)
        else $error("drivers disabled with a motor moving");

    // a stopped motor never steps
    a_step_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_step_first || m_step_second) |->
            (!m_step_first || m_speed_first != '0) &&
            (!m_step_second || m_speed_second != '0))
        else $error("step pulse on a stopped motor");

endmodule

bind dual_stepper_step_generator_unit dss_checker u_chk (.*);

// File: bench/stepper_pulse_checker.sv
// ----------------------------------------------------------------------------
// stepper_pulse_checker
// Watches the command and result channels of the dual stepper step
// generator. Keeps its own copy of the motor state and register values,
// predicts one result per accepted command or tick, and compares every
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module stepper_pulse_checker import dss_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_func,
    input  logic                      s_motor,
    input  logic signed [SPEED_W-1:0] s_speed,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_step_first,
    input  logic                      m_step_second,
    input  logic                      m_dir_first,
    input  logic                      m_dir_second,
    input  logic                      m_drivers_disabled,
    input  logic signed [SPEED_W-1:0] m_speed_first,
    input  logic signed [SPEED_W-1:0] m_speed_second,
    output int                        mismatch_count,
    output int                        outstanding
);

    typedef struct packed {
        logic                      step_first;
        logic                      step_second;
        logic                      dir_first;
        logic                      dir_second;
        logic                      drivers_disabled;
        logic signed [SPEED_W-1:0] speed_first;
        logic signed [SPEED_W-1:0] speed_second;
    } pulse_result_t;

    // sub-periods lengthened by the remainder eighths, in order
    localparam logic [IDX_W-1:0] LENGTHEN_ORDER [0:6] = '{
        3'd1, 3'd5, 3'd3, 3'd7, 3'd0, 3'd4, 3'd2
    };

    logic [MAXS_W-1:0]         speed_limit;
    logic [ACC_W-1:0]          ramp_step;
    logic [RATE_W-1:0]         rate_num;
    logic                      reverse_sense;

    logic signed [SPEED_W-1:0] motor_speed [2];
    logic                      heading [2];
    logic                      halted [2];
    logic [CNT_W-1:0]          sub_period [2][SUB_PERIODS];
    logic [CNT_W-1:0]          tick_count [2];
    logic [IDX_W-1:0]          slot [2];
    logic                      dir_level [2];
    logic                      drivers_off;

    pulse_result_t             predicted_pulses [$];
    pulse_result_t             want;

    task automatic flag(string what, int got, int exp_val);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d",
                 $time, what, got, exp_val);
    endtask

    function automatic pulse_result_t advance_motors(func_t fn, logic mot,
                                                     logic signed [SPEED_W-1:0] target);
        pulse_result_t r;
        logic [1:0]    steps;
        int            lim, acc, goal, diff, cur, mag, base, extra;
        r = '0;
        steps = '0;
        if (fn == FUNC_SET_SPEED) begin
            lim  = int'(speed_limit);
            acc  = int'(ramp_step);
            goal = int'(target);
            cur  = int'(motor_speed[mot]);
            if (goal > lim)
                goal = lim;
            if (goal < -lim)
                goal = -lim;
            diff = goal - cur;
            if (diff > acc)
                cur = cur + acc;
            else if (diff < -acc)
                cur = cur - acc;
            else
                cur = goal;
            motor_speed[mot] = cur[SPEED_W-1:0];
            if (cur == 0) begin
                halted[mot] = 1'b1;
                for (int k = 0; k < SUB_PERIODS; k++)
                    sub_period[mot][k] = IDLE_PERIOD;
            end else begin
                halted[mot]  = 1'b0;
                heading[mot] = (cur < 0) ^ reverse_sense;
                mag   = (cur < 0) ? -cur : cur;
                base  = int'(rate_num) / mag;
                extra = ((int'(rate_num) % mag) * 8) / mag;
                for (int k = 0; k < SUB_PERIODS; k++)
                    sub_period[mot][k] = base[CNT_W-1:0];
                for (int k = 0; k < 7; k++)
                    if (k < extra)
                        sub_period[mot][LENGTHEN_ORDER[k]] += 1'b1;
            end
            drivers_off = (motor_speed[0] == 0) && (motor_speed[1] == 0);
        end else begin
            for (int m = 0; m < 2; m++) begin
                tick_count[m] = tick_count[m] + 1'b1;
                if (tick_count[m] >= sub_period[m][slot[m]]) begin
                    tick_count[m] = '0;
                    if (!halted[m]) begin
                        dir_level[m] = heading[m];
                        slot[m]      = slot[m] + 1'b1;
                        steps[m]     = 1'b1;
                    end
                end
            end
        end
        r.step_first       = steps[0];
        r.step_second      = steps[1];
        r.dir_first        = dir_level[0];
        r.dir_second       = dir_level[1];
        r.drivers_disabled = drivers_off;
        r.speed_first      = motor_speed[0];
        r.speed_second     = motor_speed[1];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit   = 15'd500;
            ramp_step     = 8'd4;
            rate_num      = 16'd1000;
            reverse_sense = 1'b0;
            for (int m = 0; m < 2; m++) begin
                motor_speed[m] = '0;
                heading[m]     = 1'b0;
                halted[m]      = 1'b1;
                tick_count[m]  = '0;
                slot[m]        = '0;
                dir_level[m]   = 1'b0;
                for (int k = 0; k < SUB_PERIODS; k++)
                    sub_period[m][k] = IDLE_PERIOD;
            end
            drivers_off = 1'b0;
            predicted_pulses.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_SPEED_CAP:  speed_limit   = cfg_wdata[MAXS_W-1:0];
                    REG_ACCEL_STEP: ramp_step     = cfg_wdata[ACC_W-1:0];
                    REG_RATE_NUM:   rate_num      = cfg_wdata[RATE_W-1:0];
                    REG_REVERSE:    reverse_sense = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predicted_pulses.push_back(advance_motors(func_t'(s_func), s_motor, s_speed));
            if (m_valid && m_ready) begin
                if (predicted_pulses.size() == 0) begin
                    flag("result with no transaction pending", 1, 0);
                end else begin
                    want = predicted_pulses.pop_front();
                    if (m_step_first !== want.step_first)
                        flag("step_first", int'(m_step_first), int'(want.step_first));
                    if (m_step_second !== want.step_second)
                        flag("step_second", int'(m_step_second), int'(want.step_second));
                    if (m_dir_first !== want.dir_first)
                        flag("dir_first", int'(m_dir_first), int'(want.dir_first));
                    if (m_dir_second !== want.dir_second)
                        flag("dir_second", int'(m_dir_second), int'(want.dir_second));
                    if (m_drivers_disabled !== want.drivers_disabled)
                        flag("drivers_disabled", int'(m_drivers_disabled),
                             int'(want.drivers_disabled));
                    if (m_speed_first !== want.speed_first)
                        flag("speed_first", int'(m_speed_first), int'(want.speed_first));
                    if (m_speed_second !== want.speed_second)
                        flag("speed_second", int'(m_speed_second), int'(want.speed_second));
                end
            end
        end
        outstanding <= predicted_pulses.size();
    end

endmodule

// File: bench/dual_stepper_step_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// dual_stepper_step_generator_unit_tb
// Drives set-speed commands and timer ticks into the dual stepper step
// generator in random bursts, stalls the result side on its own pattern,
// steps through several register settings including the extremes, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module dual_stepper_step_generator_unit_tb;
    import dss_pkg::*;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int PHASE_MAX   [PHASES] = '{1000, 400, 32767, 0,   300, 60, 500};
    localparam int PHASE_ACCEL [PHASES] = '{255,  0,   255,   255, 40,  7,  4};
    localparam int PHASE_RATE  [PHASES] = '{2000, 900, 65534, 1,   800, 0,  1000};
    localparam int PHASE_REV   [PHASES] = '{0,    1,   1,     0,   1,   0,  0};

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CFG_ADDR_W-1:0]     cfg_addr;
    logic [CFG_DATA_W-1:0]     cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_func;
    logic                      s_motor;
    logic signed [SPEED_W-1:0] s_speed;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_step_first;
    logic                      m_step_second;
    logic                      m_dir_first;
    logic                      m_dir_second;
    logic                      m_drivers_disabled;
    logic signed [SPEED_W-1:0] m_speed_first;
    logic signed [SPEED_W-1:0] m_speed_second;

    int mismatch_count;
    int outstanding;
    int burst_left;
    int cur_max;
    int ready_left;
    int ready_mode;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    dual_stepper_step_generator_unit DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_motor            (s_motor),
        .s_speed            (s_speed),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_step_first       (m_step_first),
        .m_step_second      (m_step_second),
        .m_dir_first        (m_dir_first),
        .m_dir_second       (m_dir_second),
        .m_drivers_disabled (m_drivers_disabled),
        .m_speed_first      (m_speed_first),
        .m_speed_second     (m_speed_second)
    );

    stepper_pulse_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_motor            (s_motor),
        .s_speed            (s_speed),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_step_first       (m_step_first),
        .m_step_second      (m_step_second),
        .m_dir_first        (m_dir_first),
        .m_dir_second       (m_dir_second),
        .m_drivers_disabled (m_drivers_disabled),
        .m_speed_first      (m_speed_first),
        .m_speed_second     (m_speed_second),
        .mismatch_count     (mismatch_count),
        .outstanding        (outstanding)
    );

    // result side stall pattern, switching to a random mode after each random-length run
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(4, 60);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 9) == 0);
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic write_reg(cfg_reg_t idx, int value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // one transaction, opening a new burst after a random gap when due
    task automatic send(func_t fn, logic mot, logic signed [SPEED_W-1:0] spd);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_func  <= fn;
        s_motor <= mot;
        s_speed <= spd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold off until every predicted result has been seen
    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (25) @(negedge aclk);
    endtask

    function automatic logic signed [SPEED_W-1:0] pick_target();
        int                        r, mag;
        logic signed [SPEED_W-1:0] v;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: begin
                mag = cur_max - $urandom_range(0, (cur_max < 20) ? cur_max : 20);
                v   = $urandom_range(0, 1) ? SPEED_W'(-mag) : SPEED_W'(mag);
            end
            4: v = '0;
            5: v = SPEED_W'($urandom);
            6: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: begin
                mag = $urandom_range(0, cur_max + 50);
                v   = $urandom_range(0, 1) ? SPEED_W'(-mag) : SPEED_W'(mag);
            end
        endcase
        return v;
    endfunction

    initial begin
        #(12 * 400000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = REG_SPEED_CAP;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_func     = FUNC_SET_SPEED;
        s_motor    = 1'b0;
        s_speed    = '0;
        burst_left = 0;
        cur_max    = 500;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // register defaults: ramp limits, clamp at both ends, stop
        send(FUNC_TICK, 1'b0, 16'sh0000);
        send(FUNC_SET_SPEED, 1'b0, 16'sh7fff);
        send(FUNC_SET_SPEED, 1'b1, 16'sh8000);
        send(FUNC_SET_SPEED, 1'b0, 16'sh0000);
        send(FUNC_SET_SPEED, 1'b1, -16'sd2);
        send(FUNC_SET_SPEED, 1'b1, 16'sh0000);
        drain();

        // small numerator so remainder eighths lengthen sub-periods
        write_reg(REG_SPEED_CAP, 32767);
        write_reg(REG_ACCEL_STEP, 255);
        write_reg(REG_RATE_NUM, 7);
        send(FUNC_SET_SPEED, 1'b0, 16'sd3);
        send(FUNC_SET_SPEED, 1'b1, -16'sd1);
        repeat (8) send(FUNC_TICK, 1'b1, 16'shffff);
        drain();

        // reversed direction sense
        write_reg(REG_REVERSE, 1);
        send(FUNC_SET_SPEED, 1'b0, -16'sd5);
        repeat (3) send(FUNC_TICK, 1'b0, 16'sh0000);
        drain();

        // zero numerator: a running motor steps every tick
        write_reg(REG_RATE_NUM, 0);
        send(FUNC_SET_SPEED, 1'b1, 16'sd1);
        repeat (2) send(FUNC_TICK, 1'b0, 16'sh5a5a);
        send(FUNC_SET_SPEED, 1'b0, 16'sh0000);
        send(FUNC_TICK, 1'b1, 16'sha5a5);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_SPEED_CAP, PHASE_MAX[p]);
            write_reg(REG_ACCEL_STEP, PHASE_ACCEL[p]);
            write_reg(REG_RATE_NUM, PHASE_RATE[p]);
            write_reg(REG_REVERSE, PHASE_REV[p]);
            cur_max = PHASE_MAX[p];
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 3) == 0)
                    send(FUNC_SET_SPEED, 1'($urandom_range(0, 1)), pick_target());
                else
                    send(FUNC_TICK, 1'($urandom_range(0, 1)), SPEED_W'($urandom));
                if ($urandom_range(0, 199) == 0)
                    drain();
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
